[rtl/core/srgb_contrast_ratio_macros.svh]
// Assertion macros for the sRGB contrast ratio block.
// Used by srgb_contrast_ratio.sv; expects clk and rst in scope.
`ifndef SRGB_CONTRAST_RATIO_MACROS_SVH
`define SRGB_CONTRAST_RATIO_MACROS_SVH

// same-cycle implication
`define SCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/scr_pkg.sv]
// Package for the sRGB contrast ratio block: widths, weights, divider
// payload type and the linearization ROM built at elaboration. No dependencies.
package scr_pkg;

  localparam int LUM_FRAC_BITS   = 16;
  localparam int RATIO_FRAC_BITS = 8;
  localparam int CHAN_W  = 8;
  localparam int NUM_CHAN = 3;
  localparam int LUM_W   = LUM_FRAC_BITS;
  localparam int ENTRY_W = LUM_W + 1;
  localparam int W_FRAC  = 16;
  localparam int PROD_W  = ENTRY_W + W_FRAC;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SUM_W   = LUM_W + 1;
  localparam int NUM_W   = SUM_W + RATIO_FRAC_BITS;
  localparam int QUO_W   = 13;
  localparam int TOP_W   = NUM_W - QUO_W;
  localparam int REM_W   = SUM_W;
  localparam int Q30     = 30;

  localparam logic [W_FRAC-1:0] WEIGHT [NUM_CHAN] = '{16'd4732, 16'd46871, 16'd13933};
  localparam logic [SUM_W-1:0] LUM_OFF = SUM_W'(((1 << LUM_FRAC_BITS) + 10) / 20);
  localparam logic [LUM_W-1:0] LUM_MAX = '1;
  localparam logic [QUO_W-1:0] RATIO_ONE  = QUO_W'(1 << RATIO_FRAC_BITS);
  localparam logic [QUO_W-1:0] RATIO_CEIL = QUO_W'(21 << RATIO_FRAC_BITS);
  localparam logic [QUO_W-1:0] MIN_CONTRAST_RST = 13'd1792;
  localparam int LIN_LIMIT = 10;

  typedef logic [ENTRY_W-1:0] curve_rom_t [256];

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [SUM_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic [LUM_W-1:0] fg;
    logic [LUM_W-1:0] bg;
  } div_data_t;

  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int k = 0; k < 4; k++) begin
      p = (p * r) >> Q30;
    end
    return p;
  endfunction

  function automatic curve_rom_t build_curve();
    curve_rom_t rom;
    longint unsigned c, x, x2, lo, hi, mid, v;
    for (int i = 0; i < 256; i++) begin
      c = longint'(i);
      if (i <= LIN_LIMIT) begin
        rom[i] = ENTRY_W'((((c * 25) << LUM_FRAC_BITS) + 41182) / 82365);
      end else begin
        x  = ((c * 1000 + 14025) << Q30) / 269025;
        x2 = (x * x) >> Q30;
        lo = 0;
        hi = (64'd1 << Q30) + 1;
        while (hi - lo > 1) begin
          mid = lo + ((hi - lo) >> 1);
          if (pow5_q30(mid) <= x2) lo = mid;
          else hi = mid;
        end
        v = (x2 * lo) >> Q30;
        rom[i] = ENTRY_W'((v + (64'd1 << (Q30 - 1 - LUM_FRAC_BITS)))
                          >> (Q30 - LUM_FRAC_BITS));
      end
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

endpackage

[rtl/core/srgb_contrast_ratio.sv]
// Top level of the sRGB contrast ratio block: front pipeline, divider cell
// chain, output register and threshold register. Depends on scr_pkg,
// scr_front, scr_div_cell and srgb_contrast_ratio_macros.svh.
//
// Usage: one transfer on s_axis carries a foreground and a background 8-bit
// color; one transfer on m_axis returns both relative luminances (Q0.16),
// the contrast ratio (Q5.8, 1.0 to 21.0, truncated) and a flag that is set
// when the ratio is at least min_contrast.
// An input transfer passes four front stages (ROM, multiply, sum, order),
// 13 divider cells at one quotient bit each and one output register before
// m_axis_tvalid; one transfer per cycle while m_axis_tready is high.
// Every stage holds its own valid bit and loads when it is empty or its
// successor moves, so when m_axis_tready is low the items close up behind
// the output register and s_axis_tready drops only once the chain is full.
// cfg_wr_en writes min_contrast; write it only while idle.
// rst (synchronous) empties all stages and sets min_contrast to 7.0.
module srgb_contrast_ratio
  import scr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fg_chan_zero, fg_chan_one, fg_chan_two, bg_chan_zero, bg_chan_one, bg_chan_two
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fg_luminance, bg_luminance, contrast_ratio, meets_target, 2 zero bits
  output logic [47:0] m_axis_tdata
);

  `include "srgb_contrast_ratio_macros.svh"

  logic [QUO_W-1:0]  min_contrast;
  logic [CHAN_W-1:0] fg_chan [NUM_CHAN];
  logic [CHAN_W-1:0] bg_chan [NUM_CHAN];

  logic      chain_valid [QUO_W+1];
  logic      chain_ready [QUO_W+1];
  div_data_t chain_data  [QUO_W+1];

  logic [LUM_W-1:0] fg_luminance, bg_luminance;
  logic [QUO_W-1:0] contrast_ratio;
  logic             meets_target;
  logic [QUO_W-1:0] ratio_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_contrast <= MIN_CONTRAST_RST;
    end else if (cfg_wr_en) begin
      min_contrast <= cfg_wr_data;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      fg_chan[k] = s_axis_tdata[k*CHAN_W +: CHAN_W];
      bg_chan[k] = s_axis_tdata[(k+NUM_CHAN)*CHAN_W +: CHAN_W];
    end
  end

  scr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .fg_chan   (fg_chan),
    .bg_chan   (bg_chan),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    scr_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  assign chain_ready[QUO_W] = !m_axis_tvalid || m_axis_tready;
  assign ratio_next = (chain_data[QUO_W].quo > RATIO_CEIL) ? RATIO_CEIL
                                                           : chain_data[QUO_W].quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (chain_ready[QUO_W]) begin
      m_axis_tvalid <= chain_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[QUO_W]) begin
      fg_luminance   <= chain_data[QUO_W].fg;
      bg_luminance   <= chain_data[QUO_W].bg;
      contrast_ratio <= ratio_next;
    end
  end

  assign meets_target = contrast_ratio >= min_contrast;
  assign m_axis_tdata = {2'b00, meets_target, contrast_ratio, bg_luminance, fg_luminance};

  `SCR_ASSERT_NOW(a_ratio_range, m_axis_tvalid,
    (contrast_ratio >= RATIO_ONE) && (contrast_ratio <= RATIO_CEIL),
    "contrast ratio out of range")
  `SCR_ASSERT_NOW(a_equal_unity, m_axis_tvalid && (fg_luminance == bg_luminance),
    contrast_ratio == RATIO_ONE, "equal luminances must give ratio 1.0")
  `SCR_ASSERT_NOW(a_ratio_floor, chain_valid[QUO_W],
    chain_data[QUO_W].quo >= RATIO_ONE, "divider result below 1.0")
  `SCR_ASSERT_NEXT(a_drain, m_axis_tvalid && m_axis_tready && !chain_valid[QUO_W],
    !m_axis_tvalid, "output register did not drain")

endmodule

[rtl/core/scr_front.sv]
// Front pipeline: curve lookup, weighting, luminance sum, ordering and
// divider setup. Depends on scr_pkg.
module scr_front
  import scr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] fg_chan [NUM_CHAN],
  input  logic [CHAN_W-1:0] bg_chan [NUM_CHAN],
  output logic              out_valid,
  input  logic              out_ready,
  output div_data_t         out_data
);

  logic [3:0] vld;
  logic [4:0] adv;

  logic [ENTRY_W-1:0] fg_ent [NUM_CHAN];
  logic [ENTRY_W-1:0] bg_ent [NUM_CHAN];
  logic [PROD_W-1:0]  fg_prod [NUM_CHAN];
  logic [PROD_W-1:0]  bg_prod [NUM_CHAN];
  logic [LUM_W-1:0]   fg_lum, bg_lum;
  logic [LUM_W-1:0]   fg_lum_next, bg_lum_next;
  logic [ACC_W-1:0]   fg_acc, bg_acc;
  logic [ACC_W-W_FRAC-1:0] fg_rnd, bg_rnd;
  logic [LUM_W-1:0]   hi_lum, lo_lum;
  logic [SUM_W-1:0]   hi_sum, lo_sum;
  logic [NUM_W-1:0]   numer;
  div_data_t          data_next;

  always_comb begin
    adv[4] = out_ready;
    for (int k = 3; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    fg_acc = '0;
    bg_acc = '0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      fg_acc = fg_acc + ACC_W'(fg_prod[k]);
      bg_acc = bg_acc + ACC_W'(bg_prod[k]);
    end
    fg_rnd = (ACC_W-W_FRAC)'((fg_acc + (ACC_W'(1) << (W_FRAC - 1))) >> W_FRAC);
    bg_rnd = (ACC_W-W_FRAC)'((bg_acc + (ACC_W'(1) << (W_FRAC - 1))) >> W_FRAC);
    fg_lum_next = (fg_rnd > (ACC_W-W_FRAC)'(LUM_MAX)) ? LUM_MAX : LUM_W'(fg_rnd);
    bg_lum_next = (bg_rnd > (ACC_W-W_FRAC)'(LUM_MAX)) ? LUM_MAX : LUM_W'(bg_rnd);
  end

  always_comb begin
    hi_lum = (fg_lum > bg_lum) ? fg_lum : bg_lum;
    lo_lum = (fg_lum > bg_lum) ? bg_lum : fg_lum;
    hi_sum = SUM_W'(hi_lum) + LUM_OFF;
    lo_sum = SUM_W'(lo_lum) + LUM_OFF;
    numer  = {hi_sum, {RATIO_FRAC_BITS{1'b0}}};
    data_next.rem = REM_W'(numer[NUM_W-1:QUO_W]);
    data_next.num = numer[QUO_W-1:0];
    data_next.den = lo_sum;
    data_next.quo = '0;
    data_next.fg  = fg_lum;
    data_next.bg  = bg_lum;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        fg_ent[k] <= CURVE_ROM[fg_chan[k]];
        bg_ent[k] <= CURVE_ROM[bg_chan[k]];
      end
    end
    if (adv[1]) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        fg_prod[k] <= PROD_W'(fg_ent[k]) * PROD_W'(WEIGHT[k]);
        bg_prod[k] <= PROD_W'(bg_ent[k]) * PROD_W'(WEIGHT[k]);
      end
    end
    if (adv[2]) begin
      fg_lum <= fg_lum_next;
      bg_lum <= bg_lum_next;
    end
    if (adv[3]) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/core/scr_div_cell.sv]
// One restoring-division cell: produces one quotient bit and passes the
// partial remainder on. Depends on scr_pkg.
module scr_div_cell
  import scr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_data_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output div_data_t out_data
);

  logic [REM_W:0] trial;
  logic           q_bit;
  div_data_t      data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    trial     = {in_data.rem, in_data.num[QUO_W-1]};
    q_bit     = trial >= {1'b0, in_data.den};
    data_next = in_data;
    data_next.rem = q_bit ? REM_W'(trial - {1'b0, in_data.den}) : REM_W'(trial);
    data_next.num = {in_data.num[QUO_W-2:0], 1'b0};
    data_next.quo = {in_data.quo[QUO_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_data <= data_next;
  end

endmodule
